FILE: sv/assert_macros.svh
// Assertion macros used by the top level of the tributary selector.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

FILE: sv/pts_pkg.sv
// Shared constants, types and helpers of the tributary selector.
package pts_pkg;

  localparam int INDEX_BITS_DEF = 32;
  localparam int AREA_BITS_DEF  = 32;

  localparam int TRIB_SLOTS   = 4;
  localparam int SLOT_BITS    = 2;
  localparam int COUNT_BITS   = 3;
  localparam int NBR_COUNT    = 8;
  localparam int NBR_POS_BITS = 3;
  localparam int MASK_BITS    = 8;
  localparam int COLS_BITS    = 16;
  localparam int CODE_BITS    = 4;
  localparam int EMIT_BITS    = 4;
  localparam int QUEUE_DEPTH  = 4;
  localparam int CFG_INDEX_BITS = 2;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_AREA_THRESHOLD = 2'd0,
    REG_GRID_COLUMNS   = 2'd1,
    REG_OUTLET_CELL    = 2'd2
  } cfg_reg_t;

  typedef enum logic [1:0] {
    STEP_NONE  = 2'b00,
    STEP_PLUS  = 2'b01,
    STEP_MINUS = 2'b10
  } step_t;

  // Row and column step of each neighbor position.
  localparam step_t ROW_STEP [NBR_COUNT] = '{
    STEP_MINUS, STEP_MINUS, STEP_MINUS, STEP_NONE,
    STEP_PLUS,  STEP_PLUS,  STEP_PLUS,  STEP_NONE
  };
  localparam step_t COL_STEP [NBR_COUNT] = '{
    STEP_PLUS,  STEP_NONE,  STEP_MINUS, STEP_MINUS,
    STEP_MINUS, STEP_NONE,  STEP_PLUS,  STEP_PLUS
  };

  typedef enum logic {
    KIND_NEXT   = 1'b0,
    KIND_OUTLET = 1'b1
  } record_kind_t;

  typedef struct packed {
    logic [TRIB_SLOTS-1:0] slot_valid;
    logic                  listing;
  } tbl_status_t;

  // Width of one queued transaction between selector and table.
  function automatic int item_bits(input int index_bits, input int area_bits);
    return 2 + area_bits + 2 * NBR_POS_BITS + index_bits;
  endfunction

  function automatic int bytes_up(input int bits);
    return ((bits + 7) / 8) * 8;
  endfunction

endpackage

FILE: sv/pts_select.sv
// Front end: qualifies neighbors and picks main and tributary in a 3-stage tree.
module pts_select
  import pts_pkg::*;
#(
  parameter int INDEX_BITS = INDEX_BITS_DEF,
  parameter int AREA_BITS  = AREA_BITS_DEF,
  localparam int ITEM_W    = item_bits(INDEX_BITS, AREA_BITS)
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [INDEX_BITS-1:0]                in_cell,
  input  logic [AREA_BITS-1:0]                 in_area,
  input  logic [MASK_BITS-1:0]                 in_mask,
  input  logic [NBR_COUNT-1:0][AREA_BITS-1:0]  in_nbr_area,
  input  logic [AREA_BITS-1:0]                 area_threshold,
  output logic                                 item_valid,
  input  logic                                 item_ready,
  output logic [ITEM_W-1:0]                    item
);

  typedef struct packed {
    logic                    m_ok;
    logic [AREA_BITS-1:0]    m_area;
    logic [NBR_POS_BITS-1:0] m_pos;
    logic                    s_ok;
    logic [AREA_BITS-1:0]    s_area;
    logic [NBR_POS_BITS-1:0] s_pos;
  } top2_t;

  typedef struct packed {
    logic                    walk_end;
    logic                    sec_ok;
    logic [AREA_BITS-1:0]    sec_area;
    logic [NBR_POS_BITS-1:0] sec_pos;
    logic [NBR_POS_BITS-1:0] main_pos;
    logic [INDEX_BITS-1:0]   stem_idx;
  } q_item_t;

  // Merge of two top-two lists; l holds the earlier neighbors, ties keep l.
  function automatic top2_t merge(input top2_t l, input top2_t r);
    top2_t res;
    logic  r_wins;
    r_wins = r.m_ok && (!l.m_ok || (r.m_area > l.m_area));
    if (r_wins) begin
      res.m_ok   = r.m_ok;
      res.m_area = r.m_area;
      res.m_pos  = r.m_pos;
      if (r.s_ok && (!l.m_ok || (r.s_area > l.m_area))) begin
        res.s_ok   = r.s_ok;
        res.s_area = r.s_area;
        res.s_pos  = r.s_pos;
      end else begin
        res.s_ok   = l.m_ok;
        res.s_area = l.m_area;
        res.s_pos  = l.m_pos;
      end
    end else begin
      res.m_ok   = l.m_ok;
      res.m_area = l.m_area;
      res.m_pos  = l.m_pos;
      if (r.m_ok && (!l.s_ok || (r.m_area > l.s_area))) begin
        res.s_ok   = r.m_ok;
        res.s_area = r.m_area;
        res.s_pos  = r.m_pos;
      end else begin
        res.s_ok   = l.s_ok;
        res.s_area = l.s_area;
        res.s_pos  = l.s_pos;
      end
    end
    return res;
  endfunction

  logic                  walk_go;
  top2_t                 leaf [NBR_COUNT];
  top2_t                 pair_nxt [NBR_COUNT/2];
  top2_t                 half_nxt [NBR_COUNT/4];
  top2_t                 full;
  q_item_t               item_nxt;
  logic                  adv1, adv2, adv3;

  logic                  s1_valid_r;
  top2_t                 s1_pair_r [NBR_COUNT/2];
  logic [INDEX_BITS-1:0] s1_cell_r;
  logic                  s2_valid_r;
  top2_t                 s2_half_r [NBR_COUNT/4];
  logic [INDEX_BITS-1:0] s2_cell_r;
  logic                  s3_valid_r;
  q_item_t               s3_item_r;

  assign adv3     = !s3_valid_r || item_ready;
  assign adv2     = !s2_valid_r || adv3;
  assign adv1     = !s1_valid_r || adv2;
  assign in_ready = adv1;

  assign walk_go = (in_area >= area_threshold) && (in_mask != '0);

  always_comb begin
    for (int p = 0; p < NBR_COUNT; p++) begin
      leaf[p].m_ok   = walk_go && in_mask[MASK_BITS-1-p] && (in_nbr_area[p] > area_threshold);
      leaf[p].m_area = in_nbr_area[p];
      leaf[p].m_pos  = NBR_POS_BITS'(p);
      leaf[p].s_ok   = 1'b0;
      leaf[p].s_area = '0;
      leaf[p].s_pos  = '0;
    end
    for (int i = 0; i < NBR_COUNT/2; i++) begin
      pair_nxt[i] = merge(leaf[2*i], leaf[2*i+1]);
    end
    for (int i = 0; i < NBR_COUNT/4; i++) begin
      half_nxt[i] = merge(s1_pair_r[2*i], s1_pair_r[2*i+1]);
    end
    full = merge(s2_half_r[0], s2_half_r[1]);
    item_nxt.walk_end = !full.m_ok;
    item_nxt.sec_ok   = full.s_ok;
    item_nxt.sec_area = full.s_area;
    item_nxt.sec_pos  = full.s_pos;
    item_nxt.main_pos = full.m_pos;
    item_nxt.stem_idx = s2_cell_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
    end else begin
      if (adv1) s1_valid_r <= in_valid;
      if (adv2) s2_valid_r <= s1_valid_r;
      if (adv3) s3_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1 && in_valid) begin
      s1_pair_r <= pair_nxt;
      s1_cell_r <= in_cell;
    end
    if (adv2 && s1_valid_r) begin
      s2_half_r <= half_nxt;
      s2_cell_r <= s1_cell_r;
    end
    if (adv3 && s2_valid_r) begin
      s3_item_r <= item_nxt;
    end
  end

  assign item_valid = s3_valid_r;
  assign item       = s3_item_r;

endmodule

FILE: sv/pts_queue.sv
// Short register queue between the front end and the tributary table.
module pts_queue
  import pts_pkg::*;
#(
  parameter int WIDTH = 8,
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_data
);

  localparam int PTR_BITS = $clog2(DEPTH);
  localparam int CNT_BITS = $clog2(DEPTH + 1);

  // DEPTH is a power of two so the pointers wrap on their own.
  logic [WIDTH-1:0]    slot_r [DEPTH];
  logic [PTR_BITS-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_BITS-1:0] count_r, count_nxt;
  logic                push, pop;

  assign push_ready = count_r != CNT_BITS'(DEPTH);
  assign pop_valid  = count_r != '0;
  assign pop_data   = slot_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) count_nxt = count_r + CNT_BITS'(1);
    else if (pop && !push) count_nxt = count_r - CNT_BITS'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + PTR_BITS'(1);
      if (pop) rd_ptr_r <= rd_ptr_r + PTR_BITS'(1);
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) slot_r[wr_ptr_r] <= push_data;
  end

endmodule

FILE: sv/pts_table.sv
// Back end: tributary table update, outlet list walk and output register.
module pts_table
  import pts_pkg::*;
#(
  parameter int INDEX_BITS = INDEX_BITS_DEF,
  parameter int AREA_BITS  = AREA_BITS_DEF,
  localparam int ITEM_W    = item_bits(INDEX_BITS, AREA_BITS)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  item_valid,
  output logic                  item_ready,
  input  logic [ITEM_W-1:0]     item,
  input  logic [COLS_BITS-1:0]  grid_columns,
  input  logic [INDEX_BITS-1:0] outlet_cell,
  output logic                  out_valid,
  input  logic                  out_ready,
  output record_kind_t          out_kind,
  output logic [INDEX_BITS-1:0] out_cell,
  output logic [CODE_BITS-1:0]  out_code,
  output logic                  out_last,
  output tbl_status_t           status
);

  typedef struct packed {
    logic                    walk_end;
    logic                    sec_ok;
    logic [AREA_BITS-1:0]    sec_area;
    logic [NBR_POS_BITS-1:0] sec_pos;
    logic [NBR_POS_BITS-1:0] main_pos;
    logic [INDEX_BITS-1:0]   stem_idx;
  } q_item_t;

  function automatic logic [INDEX_BITS-1:0] nbr_index(
    input logic [INDEX_BITS-1:0]   base_idx,
    input logic [INDEX_BITS-1:0]   cols,
    input logic [NBR_POS_BITS-1:0] pos
  );
    logic [INDEX_BITS-1:0] row_term;
    logic [INDEX_BITS-1:0] col_term;
    case (ROW_STEP[pos])
      STEP_PLUS:  row_term = cols;
      STEP_MINUS: row_term = -cols;
      default:    row_term = '0;
    endcase
    case (COL_STEP[pos])
      STEP_PLUS:  col_term = INDEX_BITS'(1);
      STEP_MINUS: col_term = '1;
      default:    col_term = '0;
    endcase
    return base_idx + row_term + col_term;
  endfunction

  q_item_t               item_q;
  logic [INDEX_BITS-1:0] cols_ext, main_cell, sec_cell;

  logic [TRIB_SLOTS-1:0] slot_valid_r;
  logic [AREA_BITS-1:0]  slot_area_r  [TRIB_SLOTS];
  logic [INDEX_BITS-1:0] trib_cell_r  [TRIB_SLOTS];
  logic [INDEX_BITS-1:0] trunk_cell_r [TRIB_SLOTS];
  logic [AREA_BITS-1:0]  min_area_r;
  logic [SLOT_BITS-1:0]  min_slot_r;
  logic [EMIT_BITS-1:0]  emit_idx_r;

  logic                  out_valid_r;
  record_kind_t          out_kind_r;
  logic [INDEX_BITS-1:0] out_cell_r;
  logic [CODE_BITS-1:0]  out_code_r;
  logic                  out_last_r;

  logic [TRIB_SLOTS-1:0] sh_valid;
  logic [AREA_BITS-1:0]  sh_area  [TRIB_SLOTS];
  logic [INDEX_BITS-1:0] sh_trib  [TRIB_SLOTS];
  logic [INDEX_BITS-1:0] sh_trunk [TRIB_SLOTS];
  logic [SLOT_BITS-1:0]  pick01, pick23, min_slot_nxt;
  logic [AREA_BITS-1:0]  area01, area23, min_area_nxt;

  logic                  out_free, fire, do_insert, list_done, list_clear;
  logic [COUNT_BITS-1:0] count;
  logic [EMIT_BITS-1:0]  last_idx, emit_idx_nxt;
  logic [SLOT_BITS-1:0]  slot_sel;
  record_kind_t          rec_kind;
  logic [INDEX_BITS-1:0] rec_cell;
  logic [CODE_BITS-1:0]  rec_code;
  logic                  rec_last;

  assign item_q    = q_item_t'(item);
  assign cols_ext  = INDEX_BITS'(grid_columns);
  assign main_cell = nbr_index(item_q.stem_idx, cols_ext, item_q.main_pos);
  assign sec_cell  = nbr_index(item_q.stem_idx, cols_ext, item_q.sec_pos);

  // Table as it would stand after an insert: drop the min slot, append at top.
  always_comb begin
    for (int i = 0; i < TRIB_SLOTS - 1; i++) begin
      if (SLOT_BITS'(i) >= min_slot_r) begin
        sh_valid[i] = slot_valid_r[i+1];
        sh_area[i]  = slot_area_r[i+1];
        sh_trib[i]  = trib_cell_r[i+1];
        sh_trunk[i] = trunk_cell_r[i+1];
      end else begin
        sh_valid[i] = slot_valid_r[i];
        sh_area[i]  = slot_area_r[i];
        sh_trib[i]  = trib_cell_r[i];
        sh_trunk[i] = trunk_cell_r[i];
      end
    end
    sh_valid[TRIB_SLOTS-1] = 1'b1;
    sh_area[TRIB_SLOTS-1]  = item_q.sec_area;
    sh_trib[TRIB_SLOTS-1]  = sec_cell;
    sh_trunk[TRIB_SLOTS-1] = main_cell;

    // first smallest area, lowest slot on ties
    pick01 = (sh_area[1] < sh_area[0]) ? 2'd1 : 2'd0;
    area01 = (sh_area[1] < sh_area[0]) ? sh_area[1] : sh_area[0];
    pick23 = (sh_area[3] < sh_area[2]) ? 2'd3 : 2'd2;
    area23 = (sh_area[3] < sh_area[2]) ? sh_area[3] : sh_area[2];
    min_slot_nxt = (area23 < area01) ? pick23 : pick01;
    min_area_nxt = (area23 < area01) ? area23 : area01;
  end

  // Valid slots always sit at the top of the table, so the k-th one is fixed.
  always_comb begin
    count = '0;
    for (int i = 0; i < TRIB_SLOTS; i++) begin
      count = count + COUNT_BITS'(slot_valid_r[i]);
    end
  end

  assign last_idx  = EMIT_BITS'({count, 1'b0});
  assign list_done = emit_idx_r == last_idx;
  assign slot_sel  = SLOT_BITS'(EMIT_BITS'(TRIB_SLOTS) - EMIT_BITS'(count)
                                + ((emit_idx_r - EMIT_BITS'(1)) >> 1));

  assign out_free   = !out_valid_r || out_ready;
  assign fire       = item_valid && out_free;
  assign do_insert  = fire && !item_q.walk_end && item_q.sec_ok
                      && (item_q.sec_area > min_area_r);
  assign list_clear = fire && item_q.walk_end && list_done;
  assign item_ready = fire && (!item_q.walk_end || list_done);

  always_comb begin
    if (!item_q.walk_end) begin
      rec_kind = KIND_NEXT;
      rec_cell = main_cell;
      rec_code = '0;
      rec_last = 1'b0;
    end else begin
      rec_kind = KIND_OUTLET;
      rec_code = CODE_BITS'(emit_idx_r + EMIT_BITS'(1));
      rec_last = list_done;
      if (emit_idx_r == '0) rec_cell = outlet_cell;
      else if (emit_idx_r[0]) rec_cell = trib_cell_r[slot_sel];
      else rec_cell = trunk_cell_r[slot_sel];
    end
    emit_idx_nxt = emit_idx_r;
    if (fire && item_q.walk_end) begin
      emit_idx_nxt = list_done ? '0 : emit_idx_r + EMIT_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      emit_idx_r   <= '0;
      slot_valid_r <= '0;
      min_area_r   <= '0;
      min_slot_r   <= '0;
      for (int i = 0; i < TRIB_SLOTS; i++) slot_area_r[i] <= '0;
    end else begin
      out_valid_r <= fire || (out_valid_r && !out_ready);
      emit_idx_r  <= emit_idx_nxt;
      if (list_clear) begin
        slot_valid_r <= '0;
        min_area_r   <= '0;
        min_slot_r   <= '0;
        for (int i = 0; i < TRIB_SLOTS; i++) slot_area_r[i] <= '0;
      end else if (do_insert) begin
        slot_valid_r <= sh_valid;
        slot_area_r  <= sh_area;
        min_area_r   <= min_area_nxt;
        min_slot_r   <= min_slot_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_insert) begin
      trib_cell_r  <= sh_trib;
      trunk_cell_r <= sh_trunk;
    end
    if (fire) begin
      out_kind_r <= rec_kind;
      out_cell_r <= rec_cell;
      out_code_r <= rec_code;
      out_last_r <= rec_last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_kind  = out_kind_r;
  assign out_cell  = out_cell_r;
  assign out_code  = out_code_r;
  assign out_last  = out_last_r;

  assign status.slot_valid = slot_valid_r;
  assign status.listing    = emit_idx_r != '0;

endmodule

FILE: sv/pfafstetter_tributary_selector.sv
// Top level of the Pfafstetter tributary selector: config, front end, queue, table.
// Usage:
//   in_*  : one main-stem cell per transaction (index, area, upstream mask,
//           eight neighbor areas). Accepted whenever in_tready is high.
//   out_* : records. tuser 0 = next main-stem cell, tuser 1 = sub-basin outlet
//           record with code in tdata; tlast marks the end of an outlet list.
//   cfg_* : register writes (threshold, grid columns, outlet cell), always
//           ready; write only while no cell is in flight.
// Path: a next-cell record passes the three selection stages, one queue slot
//   and the output register before it is valid on out_*.
// Throughput: one cell per cycle while the walk goes on and out_tready is high.
//   A walk end produces 2n+1 outlet records (n = kept tributaries, up to 4),
//   one per cycle while out_tready is high; the table unit is busy with them
//   while the front end keeps accepting into its 3 stages and the 4-entry queue.
// Reset: empties pipeline, queue and output register, clears the tributary
//   table and sets registers to threshold 0, columns 1, outlet 0.
// Stall: the output register holds its record while out_tready is low; the
//   queue and the front stages fill, then in_tready drops.
`include "assert_macros.svh"

module pfafstetter_tributary_selector
  import pts_pkg::*;
#(
  parameter int INDEX_BITS = INDEX_BITS_DEF,
  parameter int AREA_BITS  = AREA_BITS_DEF,
  localparam int IN_W  = bytes_up(INDEX_BITS + (1 + NBR_COUNT) * AREA_BITS + MASK_BITS),
  localparam int OUT_W = bytes_up(INDEX_BITS + CODE_BITS),
  localparam int CFG_W = (INDEX_BITS > AREA_BITS) ? INDEX_BITS : AREA_BITS
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  // cell_index, cell_area, upstream_mask, nbr_area_0 .. nbr_area_7
  input  logic [IN_W-1:0]           in_tdata,
  output logic                      out_tvalid,
  input  logic                      out_tready,
  // cell_out, basin_code
  output logic [OUT_W-1:0]          out_tdata,
  // record_kind
  output logic                      out_tuser,
  output logic                      out_tlast,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_W-1:0]          cfg_data
);

  localparam int ITEM_W   = item_bits(INDEX_BITS, AREA_BITS);
  localparam int OFF_AREA = INDEX_BITS;
  localparam int OFF_MASK = INDEX_BITS + AREA_BITS;
  localparam int OFF_NBR  = OFF_MASK + MASK_BITS;

  logic [AREA_BITS-1:0]                area_threshold_r;
  logic [COLS_BITS-1:0]                grid_columns_r;
  logic [INDEX_BITS-1:0]               outlet_cell_r;

  logic [NBR_COUNT-1:0][AREA_BITS-1:0] nbr_area;
  logic                                sel_valid, sel_ready;
  logic [ITEM_W-1:0]                   sel_item;
  logic                                q_pop_valid, q_pop_ready;
  logic [ITEM_W-1:0]                   q_pop_data;
  record_kind_t                        out_kind;
  logic [INDEX_BITS-1:0]               out_cell;
  logic [CODE_BITS-1:0]                out_code;
  tbl_status_t                         tbl_status;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      area_threshold_r <= '0;
      grid_columns_r   <= COLS_BITS'(1);
      outlet_cell_r    <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_AREA_THRESHOLD: area_threshold_r <= cfg_data[AREA_BITS-1:0];
        REG_GRID_COLUMNS:   grid_columns_r   <= cfg_data[COLS_BITS-1:0];
        REG_OUTLET_CELL:    outlet_cell_r    <= cfg_data[INDEX_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int p = 0; p < NBR_COUNT; p++) begin
      nbr_area[p] = in_tdata[OFF_NBR + p*AREA_BITS +: AREA_BITS];
    end
  end

  pts_select #(
    .INDEX_BITS (INDEX_BITS),
    .AREA_BITS  (AREA_BITS)
  ) u_select (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_tvalid),
    .in_ready       (in_tready),
    .in_cell        (in_tdata[INDEX_BITS-1:0]),
    .in_area        (in_tdata[OFF_AREA +: AREA_BITS]),
    .in_mask        (in_tdata[OFF_MASK +: MASK_BITS]),
    .in_nbr_area    (nbr_area),
    .area_threshold (area_threshold_r),
    .item_valid     (sel_valid),
    .item_ready     (sel_ready),
    .item           (sel_item)
  );

  pts_queue #(
    .WIDTH (ITEM_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (sel_valid),
    .push_ready (sel_ready),
    .push_data  (sel_item),
    .pop_valid  (q_pop_valid),
    .pop_ready  (q_pop_ready),
    .pop_data   (q_pop_data)
  );

  pts_table #(
    .INDEX_BITS (INDEX_BITS),
    .AREA_BITS  (AREA_BITS)
  ) u_table (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (q_pop_valid),
    .item_ready   (q_pop_ready),
    .item         (q_pop_data),
    .grid_columns (grid_columns_r),
    .outlet_cell  (outlet_cell_r),
    .out_valid    (out_tvalid),
    .out_ready    (out_tready),
    .out_kind     (out_kind),
    .out_cell     (out_cell),
    .out_code     (out_code),
    .out_last     (out_tlast),
    .status       (tbl_status)
  );

  assign out_tdata = OUT_W'({out_code, out_cell});
  assign out_tuser = out_kind;

  `ASSERT_IMP(a_slots_packed_high, 1'b1, (tbl_status.slot_valid == 4'b0000) || (tbl_status.slot_valid == 4'b1000) || (tbl_status.slot_valid == 4'b1100) || (tbl_status.slot_valid == 4'b1110) || (tbl_status.slot_valid == 4'b1111))
  `ASSERT_IMP(a_listing_holds_item, tbl_status.listing, q_pop_valid)
  `ASSERT_IMP(a_last_only_outlet, out_tvalid && out_tlast, out_tuser == KIND_OUTLET)
  `ASSERT_NEXT(a_cols_written, cfg_valid && cfg_ready && (cfg_index == REG_GRID_COLUMNS), grid_columns_r == $past(cfg_data[COLS_BITS-1:0]))

endmodule
